// ===== design/hrfpw_pkg.sv =====
package hrfpw_pkg;

  typedef enum logic [2:0] {
    CMD_BAD,
    CMD_DATA,
    CMD_END,
    CMD_OTHER,
    CMD_TIMEOUT
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ACK,
    KIND_WORD,
    KIND_SET,
    KIND_CLEAR,
    KIND_END
  } kind_e;

  typedef enum logic [1:0] {
    ACK_OK,
    ACK_DONE,
    ACK_ERR
  } ack_e;

  localparam logic [15:0] NO_PAGE     = 16'hFFFF;
  localparam logic [31:0] MARK_SET    = 32'hDEADBEEF;
  localparam logic [31:0] MARK_CLEAR  = 32'hFFFFFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;
  localparam logic [7:0]  TYPE_DATA   = 8'h00;
  localparam logic [7:0]  TYPE_EOF    = 8'h01;

  typedef struct packed {
    cmd_e        ctype;
    logic [15:0] addr;
    logic [7:0]  len;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    ack_e        ack;
    logic [15:0] addr;
    logic [31:0] data;
    logic        commit;
    logic        result;
    logic        last;
  } res_t;

endpackage

// ===== design/hrfpw_front.sv =====
module hrfpw_front #(
  parameter int PACKET_BYTES = 64,
  localparam int IdxW = $clog2(PACKET_BYTES),
  localparam int PosW = $clog2(PACKET_BYTES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          byte_i,
  input  logic                start_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i,
  output logic                push_o,
  output hrfpw_pkg::cmd_t     cmd_o,
  input  logic                fifo_full_i,
  input  logic                copy_done_i,
  input  logic [IdxW-1:0]     rec_raddr_i,
  output logic [7:0]          rec_rdata_o
);

  logic [PosW-1:0] pos_q, pos_d, npos;
  logic [7:0]      len_q, len_d, type_q, type_d, sum_q, sum_d, sum_b;
  logic [15:0]     addr_q, addr_d, idle_q, idle_d, tmo_q;
  logic            over_q, over_d, hold_q, hold_d;
  logic            acc, rec_we;
  logic [9:0]      k10;
  logic [16:0]     tick;
  logic [7:0]      rec_mem [PACKET_BYTES];
  logic [7:0]      rec_rdata_q;

  assign in_ready_o  = !fifo_full_i && !hold_q;
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && in_ready_o;
  assign npos        = (start_i ? '0 : pos_q) + PosW'(1);
  assign sum_b       = sum_q + byte_i;
  assign k10         = 10'(npos) - 10'd5;
  assign tick        = {1'b0, idle_q} + 17'd1;
  assign rec_rdata_o = rec_rdata_q;

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    type_d = type_q;
    sum_d  = sum_q;
    addr_d = addr_q;
    idle_d = idle_q;
    over_d = over_q;
    hold_d = hold_q && !copy_done_i;
    push_o = 1'b0;
    rec_we = 1'b0;
    cmd_o.ctype = hrfpw_pkg::CMD_BAD;
    cmd_o.addr  = addr_q;
    cmd_o.len   = len_q;
    if (acc && !over_q) begin
      if (op_i) begin
        if (tick > {1'b0, tmo_q}) begin
          push_o      = 1'b1;
          cmd_o.ctype = hrfpw_pkg::CMD_TIMEOUT;
          over_d      = 1'b1;
          pos_d       = '0;
        end else begin
          idle_d = tick[15:0];
        end
      end else if (start_i || pos_q != '0) begin
        pos_d = npos;
        if (npos == PosW'(1)) begin
          len_d = byte_i;
          sum_d = byte_i;
        end else if (npos == PosW'(2)) begin
          addr_d = {byte_i, 8'h00};
          sum_d  = sum_b;
        end else if (npos == PosW'(3)) begin
          addr_d = {addr_q[15:8], byte_i};
          sum_d  = sum_b;
        end else if (npos == PosW'(4)) begin
          type_d = byte_i;
          sum_d  = sum_b;
        end else if ({2'b00, len_q} + 10'd5 > 10'(PACKET_BYTES)) begin
          if (10'(npos) >= 10'(PACKET_BYTES)) begin
            push_o = 1'b1;
            pos_d  = '0;
            idle_d = '0;
          end
        end else if (k10 < {2'b00, len_q}) begin
          rec_we = 1'b1;
          sum_d  = sum_b;
        end else begin
          push_o = 1'b1;
          pos_d  = '0;
          idle_d = '0;
          if (sum_b == 8'h00) begin
            if (type_q == hrfpw_pkg::TYPE_DATA) begin
              cmd_o.ctype = hrfpw_pkg::CMD_DATA;
              hold_d      = 1'b1;
            end else if (type_q == hrfpw_pkg::TYPE_EOF) begin
              cmd_o.ctype = hrfpw_pkg::CMD_END;
              over_d      = 1'b1;
            end else begin
              cmd_o.ctype = hrfpw_pkg::CMD_OTHER;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
      sum_q  <= '0;
      addr_q <= '0;
      idle_q <= '0;
      over_q <= 1'b0;
      hold_q <= 1'b0;
      tmo_q  <= hrfpw_pkg::TIMEOUT_RST;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      type_q <= type_d;
      sum_q  <= sum_d;
      addr_q <= addr_d;
      idle_q <= idle_d;
      over_q <= over_d;
      hold_q <= hold_d;
      if (cfg_valid_i) begin
        tmo_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[k10[IdxW-1:0]] <= byte_i;
    end
    rec_rdata_q <= rec_mem[rec_raddr_i];
  end

endmodule

// ===== design/hrfpw_cmd_fifo.sv =====
module hrfpw_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrfpw_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hrfpw_pkg::cmd_t data_o
);

  hrfpw_pkg::cmd_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== design/hrfpw_back.sv =====
module hrfpw_back #(
  parameter int PAGE_BYTES   = 128,
  parameter int PACKET_BYTES = 64,
  localparam int IdxW  = $clog2(PACKET_BYTES),
  localparam int OffW  = $clog2(PAGE_BYTES),
  localparam int Words = (PAGE_BYTES + 3) / 4,
  localparam int WaW   = $clog2(Words)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  hrfpw_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            copy_done_o,
  output logic [IdxW-1:0] rec_raddr_o,
  input  logic [7:0]      rec_rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hrfpw_pkg::res_t out_o
);

  localparam int          ShW   = 16 + OffW;
  localparam logic [16:0] Recip = 17'(((1 << ShW) + PAGE_BYTES - 1) / PAGE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_REM, S_SET, S_PAGE, S_FRD, S_FWORD, S_FILL, S_CRD, S_CWR,
    S_CLEAR, S_ACK, S_END
  } state_e;

  state_e          st_q, st_d;
  hrfpw_pkg::cmd_t cmd_q, cmd_d;
  hrfpw_pkg::res_t res, out_q;
  logic [OffW-1:0] rem_q, rem_d;
  logic [15:0]     quo_q, quo_d;
  logic [32:0]     prod;
  logic [WaW-1:0]  w_q, w_d;
  logic [8:0]      i_q, i_d;
  logic [15:0]     open_q, open_d, page_base;
  logic            pv_q, pv_d, dirty_q, dirty_d, fm_q, fm_d, outv_q;
  logic            emit, emit_ok, fill_we, byte_we, prd, copy_go;
  logic [9:0]      off_i;
  logic [31:0]     page_mem [Words];
  logic [31:0]     rdata_q;

  assign emit_ok     = !outv_q || out_ready_i;
  assign prod        = 33'(cmd_q.addr) * 33'(Recip);
  assign page_base   = cmd_q.addr - 16'(rem_q);
  assign off_i       = 10'(rem_q) + {1'b0, i_q};
  assign copy_go     = (i_q < {1'b0, cmd_q.len}) && (off_i < 10'(PAGE_BYTES));
  assign rec_raddr_o = i_q[IdxW-1:0];
  assign out_valid_o = outv_q;
  assign out_o       = out_q;

  always_comb begin
    st_d    = st_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    w_d     = w_q;
    i_d     = i_q;
    open_d  = open_q;
    pv_d    = pv_q;
    dirty_d = dirty_q;
    fm_d    = fm_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    fill_we = 1'b0;
    byte_we = 1'b0;
    prd     = 1'b0;
    copy_done_o = 1'b0;
    res = '{kind: hrfpw_pkg::KIND_ACK, ack: hrfpw_pkg::ACK_OK, addr: '0, data: '0,
            commit: 1'b0, result: 1'b0, last: 1'b0};
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          case (cmd_i.ctype)
            hrfpw_pkg::CMD_DATA: begin
              rem_d = '0;
              st_d  = S_MOD;
            end
            hrfpw_pkg::CMD_END: begin
              w_d  = '0;
              st_d = (pv_q && dirty_q) ? S_FRD : S_CLEAR;
            end
            hrfpw_pkg::CMD_TIMEOUT: st_d = fm_q ? S_END : S_CLEAR;
            default: st_d = S_ACK;
          endcase
        end
      end
      S_MOD: begin
        quo_d = 16'(prod >> ShW);
        st_d  = S_REM;
      end
      S_REM: begin
        rem_d = OffW'(cmd_q.addr - quo_q * 16'(PAGE_BYTES));
        st_d  = fm_q ? S_PAGE : S_SET;
      end
      S_SET: begin
        if (emit_ok) begin
          emit     = 1'b1;
          res.kind = hrfpw_pkg::KIND_SET;
          res.data = hrfpw_pkg::MARK_SET;
          fm_d     = 1'b1;
          st_d     = S_PAGE;
        end
      end
      S_PAGE: begin
        w_d = '0;
        i_d = '0;
        if (!pv_q || open_q != page_base) begin
          if (pv_q && dirty_q) begin
            st_d = S_FRD;
          end else begin
            open_d  = page_base;
            pv_d    = 1'b1;
            dirty_d = 1'b0;
            st_d    = S_FILL;
          end
        end else begin
          st_d = S_CRD;
        end
      end
      S_FRD: begin
        prd  = 1'b1;
        st_d = S_FWORD;
      end
      S_FWORD: begin
        if (emit_ok) begin
          emit       = 1'b1;
          res.kind   = hrfpw_pkg::KIND_WORD;
          res.addr   = open_q + {14'(w_q), 2'b00};
          res.data   = rdata_q;
          res.commit = w_q == WaW'(Words - 1);
          if (w_q == WaW'(Words - 1)) begin
            dirty_d = 1'b0;
            w_d     = '0;
            if (cmd_q.ctype == hrfpw_pkg::CMD_DATA) begin
              open_d = page_base;
              pv_d   = 1'b1;
              st_d   = S_FILL;
            end else begin
              st_d = S_CLEAR;
            end
          end else begin
            w_d  = w_q + WaW'(1);
            st_d = S_FRD;
          end
        end
      end
      S_FILL: begin
        fill_we = 1'b1;
        if (w_q == WaW'(Words - 1)) begin
          i_d  = '0;
          st_d = S_CRD;
        end else begin
          w_d = w_q + WaW'(1);
        end
      end
      S_CRD: begin
        if (copy_go) begin
          st_d = S_CWR;
        end else begin
          copy_done_o = 1'b1;
          st_d        = S_ACK;
        end
      end
      S_CWR: begin
        byte_we = 1'b1;
        dirty_d = 1'b1;
        i_d     = i_q + 9'd1;
        st_d    = S_CRD;
      end
      S_CLEAR: begin
        if (emit_ok) begin
          emit     = 1'b1;
          res.kind = hrfpw_pkg::KIND_CLEAR;
          res.data = hrfpw_pkg::MARK_CLEAR;
          st_d     = (cmd_q.ctype == hrfpw_pkg::CMD_END) ? S_ACK : S_END;
        end
      end
      S_ACK: begin
        if (emit_ok) begin
          emit     = 1'b1;
          res.last = cmd_q.ctype != hrfpw_pkg::CMD_END;
          case (cmd_q.ctype)
            hrfpw_pkg::CMD_BAD: res.ack = hrfpw_pkg::ACK_ERR;
            hrfpw_pkg::CMD_END: res.ack = hrfpw_pkg::ACK_DONE;
            default:            res.ack = hrfpw_pkg::ACK_OK;
          endcase
          st_d = (cmd_q.ctype == hrfpw_pkg::CMD_END) ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (emit_ok) begin
          emit       = 1'b1;
          res.kind   = hrfpw_pkg::KIND_END;
          res.result = cmd_q.ctype == hrfpw_pkg::CMD_END;
          res.last   = 1'b1;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cmd_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      w_q     <= '0;
      i_q     <= '0;
      open_q  <= hrfpw_pkg::NO_PAGE;
      pv_q    <= 1'b0;
      dirty_q <= 1'b0;
      fm_q    <= 1'b0;
      outv_q  <= 1'b0;
      out_q   <= '0;
    end else begin
      st_q    <= st_d;
      cmd_q   <= cmd_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      w_q     <= w_d;
      i_q     <= i_d;
      open_q  <= open_d;
      pv_q    <= pv_d;
      dirty_q <= dirty_d;
      fm_q    <= fm_d;
      if (emit) begin
        outv_q <= 1'b1;
        out_q  <= res;
      end else if (out_ready_i) begin
        outv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      page_mem[w_q] <= '1;
    end else if (byte_we) begin
      page_mem[WaW'(off_i[OffW-1:0] >> 2)][8*off_i[1:0] +: 8] <= rec_rdata_i;
    end
    if (prd) begin
      rdata_q <= page_mem[w_q];
    end
  end

endmodule

// ===== design/hex_record_flash_page_writer.sv =====
// Channel | Direction | Handshake              | Content
// s_axis  | in        | tvalid/tready          | packet byte or millisecond tick
// m_axis  | out       | tvalid/tready, tlast   | acks, page words, set/clear markers, session end
// cfg     | in        | cfg_valid/cfg_ready    | timeout_ms
// A byte or tick is taken while s_axis_tready is high. For a data record the back end
// finds the page offset, flushes a dirty open page and fills a new one with 0xFF when
// the page changes, then copies each data byte. A flush sends one page word at a time.
// Reset is asynchronous and active low; no clearing pass is needed after reset.
// The front stalls while the command queue is full or a data record is being copied.
module hex_record_flash_page_writer #(
  parameter int PAGE_BYTES   = 128,
  parameter int PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // operation, packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // ack_code, flash_address, flash_data,
                                      // page_commit, session_result, zero pad
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int IdxW = $clog2(PACKET_BYTES);

  hrfpw_pkg::cmd_t f_cmd, q_cmd;
  hrfpw_pkg::res_t res;
  logic            push, full, q_valid, pop, copy_done;
  logic [IdxW-1:0] rec_raddr;
  logic [7:0]      rec_rdata;

  hrfpw_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser[0]),
    .byte_i     (s_axis_tdata),
    .start_i    (s_axis_tuser[1]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .push_o     (push),
    .cmd_o      (f_cmd),
    .fifo_full_i(full),
    .copy_done_i(copy_done),
    .rec_raddr_i(rec_raddr),
    .rec_rdata_o(rec_rdata)
  );

  hrfpw_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .data_i (f_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_cmd)
  );

  hrfpw_back #(.PAGE_BYTES(PAGE_BYTES), .PACKET_BYTES(PACKET_BYTES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .pop_o      (pop),
    .copy_done_o(copy_done),
    .rec_raddr_o(rec_raddr),
    .rec_rdata_i(rec_rdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tdata = {4'b0000, res.result, res.commit, res.data, res.addr, res.ack};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  a_ack_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != hrfpw_pkg::KIND_ACK |-> m_axis_tdata[1:0] == 2'b00)
    else $error("ack code on a non-ack result");
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tuser == hrfpw_pkg::KIND_WORD)
    else $error("page commit on a non-word result");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[51] |-> m_axis_tuser == hrfpw_pkg::KIND_END && m_axis_tlast)
    else $error("session result outside session end");

endmodule
